// ===== hdl/ohmr_pkg.sv =====
package ohmr_pkg;

    // Widths fixed by the result fields and by the largest reference resistor.
    localparam int RES_W  = 27;
    localparam int RREF_W = 17;
    localparam int QLOW_W = 17;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register index, taken from the word-address bit of paddr.
    localparam logic REG_REF_SELECT = 1'b0;

    typedef enum logic [1:0] {
        REF_DEFAULT = 2'd0,
        REF_1K      = 2'd1,
        REF_10K     = 2'd2,
        REF_100K    = 2'd3
    } ref_sel_t;

    localparam logic [RREF_W-1:0] RREF_1K_OHM   = 17'd1000;
    localparam logic [RREF_W-1:0] RREF_10K_OHM  = 17'd10000;
    localparam logic [RREF_W-1:0] RREF_100K_OHM = 17'd100000;

    localparam logic [QLOW_W-1:0] LIMIT_OVF    = 17'd100000;
    localparam logic [QLOW_W-1:0] LIMIT_POINT  = 17'd10000;
    localparam logic [QLOW_W-1:0] LIMIT_RANGE7 = 17'd70000;
    localparam logic [QLOW_W-1:0] LIMIT_LOW    = 17'd50;

    // Reciprocal multipliers: x / 1000 and x / 100 both as (x * M) >> 27,
    // exact for the value ranges that reach them. x / 10 as (x * 205) >> 11.
    localparam int                RECIP_W       = 21;
    localparam int                RECIP_SHIFT   = 27;
    localparam logic [RECIP_W-1:0] RECIP_DIV1000 = 21'd134218;
    localparam logic [RECIP_W-1:0] RECIP_DIV100  = 21'd1342208;
    localparam int                DIV10_W       = 15;
    localparam int                DIV10_SHIFT   = 11;
    localparam logic [7:0]        RECIP_DIV10   = 8'd205;

    localparam logic [6:0] SEG_DASH   = 7'h3F;
    localparam logic [7:0] UNITS_DASH = 8'hBF;
    localparam logic [2:0] RANGE_MAX  = 3'd7;

    // Active-low gfedcba pattern of one decimal digit.
    function automatic logic [6:0] seg7(input logic [3:0] digit);
        logic [6:0] pattern;
        unique case (digit)
            4'd0:    pattern = 7'h40;
            4'd1:    pattern = 7'h79;
            4'd2:    pattern = 7'h24;
            4'd3:    pattern = 7'h30;
            4'd4:    pattern = 7'h19;
            4'd5:    pattern = 7'h12;
            4'd6:    pattern = 7'h02;
            4'd7:    pattern = 7'h78;
            4'd8:    pattern = 7'h00;
            4'd9:    pattern = 7'h10;
            default: pattern = 7'h7F;
        endcase
        return pattern;
    endfunction

endpackage

// ===== hdl/ohmmeter_readout.sv =====
// Stages from an accepted sample to its result item: one product stage, one
//   divider cell per quotient bit (ADC_BITS + 17 cells), and two display stages.
// Throughput: one item per cycle while no result stall backs up the chain;
//   every stage holds its own item.
// Reset (rst_n low, asynchronous) empties all stages and sets reference
//   select to 1 (1 kOhm reference).
module ohmmeter_readout
    import ohmr_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // Sample channel.
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic [ADC_BITS-1:0] adc_steps,
    // Result channel.
    output logic                result_valid,
    input  logic                result_stall,
    output logic [RES_W-1:0]    resistance_ohm,
    output logic [6:0]          tens_segments,
    output logic [7:0]          units_segments,
    output logic [2:0]          range_code,
    output logic                low_resistance
);

    localparam int NUM_W = ADC_BITS + RREF_W;
    localparam int DEN_W = ADC_BITS + 1;

    // The single configuration register selects the reference resistor.
    // Code 0 behaves as the 1 kOhm setting.
    ref_sel_t ref_sel_reg;
    logic     cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_REF_SELECT);
    assign prdata    = DATA_W'(ref_sel_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_sel_reg <= REF_1K;
        end
        else if (cfg_write)
        begin
            ref_sel_reg <= ref_sel_t'(pwdata[1:0]);
        end
    end

    // Every stage carries its own valid bit and moves when the next stage
    // can take its item, so bubbles collapse and a stalled result does not
    // block the stages behind it until the whole chain is full.
    logic             prod_ready;

    // Boundary signals of the divider chain: index k is the input of cell k.
    logic             c_valid [0:NUM_W];
    logic             c_ready [0:NUM_W];
    logic [NUM_W-1:0] c_num   [0:NUM_W];
    logic [NUM_W-1:0] c_quo   [0:NUM_W];
    logic [DEN_W-1:0] c_rem   [0:NUM_W];
    logic [DEN_W-1:0] c_den   [0:NUM_W];

    assign sample_stall = !prod_ready;

    // The product stage multiplies the sample by the reference resistance
    // and forms the divider 2^ADC_BITS - steps, which is never zero.
    ohmr_prod #(
        .ADC_BITS   (ADC_BITS)
    ) u_prod (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (sample_valid),
        .up_ready   (prod_ready),
        .steps      (adc_steps),
        .ref_sel    (ref_sel_reg),
        .down_valid (c_valid[0]),
        .down_ready (c_ready[0]),
        .num        (c_num[0]),
        .den        (c_den[0])
    );

    assign c_quo[0] = '0;
    assign c_rem[0] = '0;

    // Restoring division, one quotient bit per cell, most significant first.
    // After the last cell the quotient register holds floor(num / den).
    for (genvar k = 0; k < NUM_W; k++)
    begin : g_cell
        ohmr_div_cell #(
            .ADC_BITS   (ADC_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (c_valid[k]),
            .up_ready   (c_ready[k]),
            .num_in     (c_num[k]),
            .quo_in     (c_quo[k]),
            .rem_in     (c_rem[k]),
            .den_in     (c_den[k]),
            .down_valid (c_valid[k+1]),
            .down_ready (c_ready[k+1]),
            .num_out    (c_num[k+1]),
            .quo_out    (c_quo[k+1]),
            .rem_out    (c_rem[k+1]),
            .den_out    (c_den[k+1])
        );
    end

    // All display decisions work from the integer quotient: comparing it
    // with 100000, 10000, 70000 and 50 is the same as comparing the exact
    // ratio, and the shown figures are floor(q/100) or floor(q/1000).
    ohmr_format #(
        .ADC_BITS       (ADC_BITS)
    ) u_format (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (c_valid[NUM_W]),
        .up_ready       (c_ready[NUM_W]),
        .quo            (c_quo[NUM_W]),
        .down_valid     (result_valid),
        .down_ready     (!result_stall),
        .resistance_ohm (resistance_ohm),
        .tens_segments  (tens_segments),
        .units_segments (units_segments),
        .range_code     (range_code),
        .low_resistance (low_resistance)
    );

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall))
        else $error("sample stalled while the result side is free");

    a_low_is_small: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && low_resistance) |->
            (range_code == 3'd0 && !units_segments[7] && resistance_ohm < RES_W'(50)))
        else $error("low resistance flag disagrees with range or point");

    a_dash_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && tens_segments == SEG_DASH) |->
            (units_segments == UNITS_DASH && range_code == RANGE_MAX))
        else $error("overflow display incomplete");
`endif

endmodule

// ===== hdl/ohmr_prod.sv =====
module ohmr_prod
    import ohmr_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  logic [ADC_BITS-1:0]          steps,
    input  ref_sel_t                     ref_sel,
    output logic                         down_valid,
    input  logic                         down_ready,
    output logic [ADC_BITS+RREF_W-1:0]   num,
    output logic [ADC_BITS:0]            den
);

    localparam int NUM_W = ADC_BITS + RREF_W;
    localparam int DEN_W = ADC_BITS + 1;
    localparam logic [DEN_W-1:0] FULL = DEN_W'(1) << ADC_BITS;

    logic [RREF_W-1:0] rref;
    logic              load;
    logic              valid_reg;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  den_reg, den_next;

    always_comb
    begin
        unique case (ref_sel)
            REF_10K:  rref = RREF_10K_OHM;
            REF_100K: rref = RREF_100K_OHM;
            default:  rref = RREF_1K_OHM;
        endcase
    end

    assign num_next = NUM_W'(steps) * NUM_W'(rref);
    assign den_next = FULL - {1'b0, steps};

    assign up_ready = !valid_reg || down_ready;
    assign load     = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign down_valid = valid_reg;
    assign num        = num_reg;
    assign den        = den_reg;

endmodule

// ===== hdl/ohmr_div_cell.sv =====
module ohmr_div_cell
    import ohmr_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  logic [ADC_BITS+RREF_W-1:0]   num_in,
    input  logic [ADC_BITS+RREF_W-1:0]   quo_in,
    input  logic [ADC_BITS:0]            rem_in,
    input  logic [ADC_BITS:0]            den_in,
    output logic                         down_valid,
    input  logic                         down_ready,
    output logic [ADC_BITS+RREF_W-1:0]   num_out,
    output logic [ADC_BITS+RREF_W-1:0]   quo_out,
    output logic [ADC_BITS:0]            rem_out,
    output logic [ADC_BITS:0]            den_out
);

    localparam int NUM_W = ADC_BITS + RREF_W;
    localparam int DEN_W = ADC_BITS + 1;

    logic [DEN_W:0]   trial, diff;
    logic             qbit;
    logic             load;
    logic             valid_reg;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;

    // One restoring step: bring down the next numerator bit and subtract
    // the divisor when it fits.
    always_comb
    begin
        trial    = {rem_in, num_in[NUM_W-1]};
        diff     = trial - {1'b0, den_in};
        qbit     = (trial >= {1'b0, den_in});
        rem_next = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_next = {num_in[NUM_W-2:0], 1'b0};
        quo_next = {quo_in[NUM_W-2:0], qbit};
    end

    assign up_ready = !valid_reg || down_ready;
    assign load     = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= num_next;
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            den_reg <= den_in;
        end
    end

    assign down_valid = valid_reg;
    assign num_out    = num_reg;
    assign quo_out    = quo_reg;
    assign rem_out    = rem_reg;
    assign den_out    = den_reg;

`ifndef ASSERT_OFF
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (rem_reg < den_reg))
        else $error("partial remainder not below divisor");
`endif

endmodule

// ===== hdl/ohmr_format.sv =====
module ohmr_format
    import ohmr_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  logic [ADC_BITS+RREF_W-1:0]   quo,
    output logic                         down_valid,
    input  logic                         down_ready,
    output logic [RES_W-1:0]             resistance_ohm,
    output logic [6:0]                   tens_segments,
    output logic [7:0]                   units_segments,
    output logic [2:0]                   range_code,
    output logic                         low_resistance
);

    localparam int NUM_W  = ADC_BITS + RREF_W;
    localparam int PROD_W = QLOW_W + RECIP_W;

    typedef struct packed {
        logic ovf;
        logic point;
        logic low;
        logic ge70k;
    } disp_flags_t;

    // Stage A: range flags and the two-figure number.
    disp_flags_t        flags_next, flags_reg;
    logic [QLOW_W-1:0]  q_low;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod;
    logic [6:0]         n_next, n_reg;
    logic [RES_W-1:0]   res_a_reg;
    logic               va_reg, ready_a, load_a;

    // Stage B: digits and segment patterns.
    logic [DIV10_W-1:0] tens_prod;
    logic [3:0]         tens_d, units_d;
    logic [6:0]         units_full;
    logic [6:0]         tens_next;
    logic [7:0]         units_next;
    logic [2:0]         range_next;
    logic [RES_W-1:0]   res_b_reg;
    logic [6:0]         tens_reg;
    logic [7:0]         units_reg;
    logic [2:0]         range_reg;
    logic               low_reg;
    logic               vb_reg, ready_b, load_b;

    always_comb
    begin
        flags_next.ovf   = (quo >= NUM_W'(LIMIT_OVF));
        flags_next.point = (quo <  NUM_W'(LIMIT_POINT));
        flags_next.low   = (quo <  NUM_W'(LIMIT_LOW));
        flags_next.ge70k = (quo >= NUM_W'(LIMIT_RANGE7));
        q_low  = flags_next.ovf ? '0 : quo[QLOW_W-1:0];
        recip  = flags_next.point ? RECIP_DIV100 : RECIP_DIV1000;
        prod   = PROD_W'(q_low) * PROD_W'(recip);
        n_next = 7'(prod >> RECIP_SHIFT);
    end

    assign ready_b  = !vb_reg || down_ready;
    assign ready_a  = !va_reg || ready_b;
    assign load_a   = up_valid && ready_a;
    assign load_b   = va_reg && ready_b;
    assign up_ready = ready_a;

    always_comb
    begin
        tens_prod  = DIV10_W'(n_reg) * DIV10_W'(RECIP_DIV10);
        tens_d     = 4'(tens_prod >> DIV10_SHIFT);
        units_full = n_reg - 7'(tens_d) * 7'd10;
        units_d    = units_full[3:0];
        tens_next  = flags_reg.ovf ? SEG_DASH : seg7(tens_d);
        units_next = flags_reg.ovf ? UNITS_DASH : {!flags_reg.point, seg7(units_d)};
        if (flags_reg.ge70k)
        begin
            range_next = RANGE_MAX;
        end
        else if (flags_reg.point)
        begin
            range_next = 3'd0;
        end
        else
        begin
            range_next = 3'(tens_d);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= up_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            flags_reg <= flags_next;
            n_reg     <= n_next;
            res_a_reg <= RES_W'(quo);
        end
        if (load_b)
        begin
            res_b_reg <= res_a_reg;
            tens_reg  <= tens_next;
            units_reg <= units_next;
            range_reg <= range_next;
            low_reg   <= flags_reg.low;
        end
    end

    assign down_valid     = vb_reg;
    assign resistance_ohm = res_b_reg;
    assign tens_segments  = tens_reg;
    assign units_segments = units_reg;
    assign range_code     = range_reg;
    assign low_resistance = low_reg;

endmodule
